/* sv/lrupr_pkg.sv */
`timescale 1ns / 1ps

package lrupr_pkg;

    // Geometry
    localparam int FRAMES    = 4;
    localparam int PAGE_BITS = 16;
    localparam int RANK_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int IDX_W     = RANK_W;
    localparam int SLOT_W    = 2;
    localparam int COUNT_W   = 32;

    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [COUNT_W-1:0]   t_count;

    // Most recently used rank
    localparam t_rank RANK_MRU = t_rank'(FRAMES - 1);

    // Update command broadcast to every cell
    typedef struct packed {
        logic  en;        // a transaction is being accepted this cycle
        logic  load;      // miss: selected cell takes the new page
        t_rank old_rank;  // rank the selected cell held before the update
    } t_cell_cmd;

    // Status reported by each cell
    typedef struct packed {
        logic  match;     // valid and holds the looked-up page
        logic  lru;       // rank is zero
        t_rank rank;
    } t_cell_stat;

endpackage

/* sv/lrupr_cell.sv */
`timescale 1ns / 1ps

module lrupr_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrupr_pkg::t_rank      i_home_rank,
    input  lrupr_pkg::t_page      i_page,
    input  logic                  i_empty_before,
    output logic                  o_empty_before,
    output logic                  o_first_empty,
    input  logic                  i_sel,
    input  lrupr_pkg::t_cell_cmd  i_cmd,
    output lrupr_pkg::t_cell_stat o_stat
);

    lrupr_pkg::t_page r_page;
    logic             r_valid;
    logic             n_valid;
    lrupr_pkg::t_rank r_rank;
    lrupr_pkg::t_rank n_rank;

    // Empty-frame priority chain: first empty frame wins
    assign o_empty_before = i_empty_before | ~r_valid;
    assign o_first_empty  = ~r_valid & ~i_empty_before;

    // Lookup status
    assign o_stat.match = r_valid && (r_page == i_page);
    assign o_stat.lru   = (r_rank == '0);
    assign o_stat.rank  = r_rank;

    // Recency update: selected cell becomes newest, younger ones shift down
    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_cmd.en) begin
            if (i_sel) begin
                n_rank = lrupr_pkg::RANK_MRU;
                if (i_cmd.load) begin
                    n_valid = 1'b1;
                end
            end else if (r_rank > i_cmd.old_rank) begin
                n_rank = r_rank - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= i_home_rank;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    // Page store, written on a miss
    always_ff @(posedge i_clk) begin
        if (i_cmd.en && i_cmd.load && i_sel) begin
            r_page <= i_page;
        end
    end

endmodule

/* sv/lru_page_replacement_core.sv */
// Each result is registered and presented in the cycle after its input is accepted.
// Throughput: one page reference per cycle unless output stalls; lookup, victim choice
//   and recency update all complete in a single pass across the frame cell chain.
// Output register: input is taken whenever the result slot is empty or drained.
// Reset (synchronous, active low): all frames empty, ranks equal frame index,
//   fault count zero, no result pending.
`timescale 1ns / 1ps

module lru_page_replacement_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_page,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_fault,
    output logic [1:0]  o_slot,
    output logic [31:0] o_fault_count
);

    localparam int F = lrupr_pkg::FRAMES;

    logic                  accept;
    logic [F:0]            empty_chain;
    logic [F-1:0]          first_empty;
    logic [F-1:0]          match_vec;
    logic [F-1:0]          lru_vec;
    logic [F-1:0]          sel;
    lrupr_pkg::t_cell_stat stat [F];
    lrupr_pkg::t_cell_cmd  cmd;
    lrupr_pkg::t_idx       chosen;
    lrupr_pkg::t_rank      old_rank;
    logic                  hit;
    logic                  any_empty;

    logic                  r_out_valid;
    logic                  r_fault;
    logic [1:0]            r_slot;
    logic [1:0]            n_slot;
    lrupr_pkg::t_count     r_count;
    lrupr_pkg::t_count     n_count;
    logic [lrupr_pkg::SLOT_W+lrupr_pkg::IDX_W-1:0] slot_wide;

    assign o_in_ready = ~r_out_valid | i_out_ready;
    assign accept     = i_in_valid & o_in_ready;

    // Chain of frame cells
    assign empty_chain[0] = 1'b0;
    for (genvar g = 0; g < F; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_home_rank    (lrupr_pkg::t_rank'(g)),
            .i_page         (i_page),
            .i_empty_before (empty_chain[g]),
            .o_empty_before (empty_chain[g+1]),
            .o_first_empty  (first_empty[g]),
            .i_sel          (sel[g]),
            .i_cmd          (cmd),
            .o_stat         (stat[g])
        );
        assign match_vec[g] = stat[g].match;
        assign lru_vec[g]   = stat[g].lru;
    end

    assign hit       = |match_vec;
    assign any_empty = empty_chain[F];

    // Frame selection: hit, else first empty, else least recently used
    always_comb begin
        if (hit) begin
            sel = match_vec;
        end else if (any_empty) begin
            sel = first_empty;
        end else begin
            sel = lru_vec;
        end
    end

    // Encode selected frame and fetch its rank
    always_comb begin
        chosen   = '0;
        old_rank = '0;
        for (int i = 0; i < F; i++) begin
            if (sel[i]) begin
                chosen   = chosen | lrupr_pkg::t_idx'(i);
                old_rank = old_rank | stat[i].rank;
            end
        end
    end

    assign cmd.en       = accept;
    assign cmd.load     = ~hit;
    assign cmd.old_rank = old_rank;

    // Saturating fault counter
    always_comb begin
        n_count = r_count;
        if (!hit && (r_count != '1)) begin
            n_count = r_count + 1'b1;
        end
    end

    assign slot_wide = {{lrupr_pkg::SLOT_W{1'b0}}, chosen};
    assign n_slot    = slot_wide[lrupr_pkg::SLOT_W-1:0];

    // Result register and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fault <= ~hit;
            r_slot  <= n_slot;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_fault       = r_fault;
    assign o_slot        = r_slot;
    assign o_fault_count = r_count;

endmodule

/* sv/lrupr_check.sv */
`timescale 1ns / 1ps

module lrupr_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [15:0] i_page,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_fault,
    input logic [1:0]  o_slot,
    input logic [31:0] o_fault_count
);

    logic        out_acc;
    logic        r_seen;
    logic [31:0] r_last_cnt;

    assign out_acc = o_out_valid & i_out_ready;

    // Track the count carried by the previous result transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= 1'b0;
            r_last_cnt <= '0;
        end else if (out_acc) begin
            r_seen     <= 1'b1;
            r_last_cnt <= o_fault_count;
        end
    end

    // No result is pending right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_fault) && $stable(o_slot) && $stable(o_fault_count))
        else $error("stalled result changed");

    // First reference always faults into frame zero
    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !r_seen |-> o_fault && (o_slot == 2'd0) && (o_fault_count == 32'd1))
        else $error("first result wrong");

    // A hit leaves the count alone
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && !o_fault |-> o_fault_count == r_last_cnt)
        else $error("count moved on a hit");

    // A fault adds one, saturating
    a_fault_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen && o_fault |->
            (o_fault_count == r_last_cnt + 32'd1) ||
            ((r_last_cnt == 32'hFFFF_FFFF) && (o_fault_count == 32'hFFFF_FFFF)))
        else $error("count wrong on a fault");

endmodule

bind lru_page_replacement_core lrupr_check u_lrupr_check (.*);
